/* sv/vau_pkg.sv */
// Shared types and constants of the two-dimensional vector arithmetic unit.
package vau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SQRT_STEPS    = 32;
  // Squares, radicand, one stage per root bit, then rounding.
  localparam int SQRT_LAT      = SQRT_STEPS + 3;

  localparam logic signed [31:0] MAX_S32 = 32'sh7fffffff;
  localparam logic signed [31:0] MIN_S32 = 32'sh80000000;
  localparam logic [30:0]        MAX_MAG = 31'h7fffffff;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_SUB    = 3'd1,
    KIND_SCALE  = 3'd2,
    KIND_LENGTH = 3'd3,
    KIND_NORM   = 3'd4
  } kind_t;

  // Everything that travels beside the root and quotient pipelines.
  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         neg;
    logic               zero;
    logic               sat;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic [31:0]        u_x;
    logic [31:0]        u_y;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] len;
  } tail_t;

endpackage

/* sv/vau_chan_if.sv */
// Request and response channels of the vector arithmetic unit.
interface vau_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] factor;

  modport source (output valid, kind, a_x, a_y, b_x, b_y, factor, input ready);
  modport sink (input valid, kind, a_x, a_y, b_x, b_y, factor, output ready);
endinterface

interface vau_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic [30:0]        magnitude;
  logic               saturated;

  modport source (output valid, r_x, r_y, magnitude, saturated, input ready);
  modport sink (input valid, r_x, r_y, magnitude, saturated, output ready);
endinterface

/* sv/vau_lane.sv */
// One component lane: add, subtract, rounded scale and absolute value.
module vau_lane
  import vau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [2:0]         kind,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic signed [31:0] f,
  output logic [31:0]        abs_a,
  output logic signed [31:0] res,
  output logic               sat
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] HI64 = 64'(MAX_S32);
  localparam logic signed [63:0] LO64 = 64'(MIN_S32);

  logic [2:0]         kind2;
  logic signed [32:0] sum;
  logic signed [63:0] prod;
  logic signed [63:0] prod_c;
  logic signed [63:0] rnd;
  logic signed [31:0] res_next;
  logic               sat_next;

  assign prod_c = 64'(a) * 64'(f);

  always_ff @(posedge clk) begin
    if (en) begin
      kind2 <= kind;
      prod  <= prod_c;
      abs_a <= a[31] ? (~a + 32'd1) : a;
      if (kind == KIND_SUB) begin
        sum <= {a[31], a} - {b[31], b};
      end else begin
        sum <= {a[31], a} + {b[31], b};
      end
    end
  end

  assign rnd = (prod + HALF) >>> FRAC_BITS;

  always_comb begin
    res_next = '0;
    sat_next = 1'b0;
    case (kind2) inside
      KIND_ADD, KIND_SUB: begin
        if (sum[32] != sum[31]) begin
          sat_next = 1'b1;
          res_next = sum[32] ? MIN_S32 : MAX_S32;
        end else begin
          res_next = sum[31:0];
        end
      end
      KIND_SCALE: begin
        if (rnd > HI64) begin
          sat_next = 1'b1;
          res_next = MAX_S32;
        end else if (rnd < LO64) begin
          sat_next = 1'b1;
          res_next = MIN_S32;
        end else begin
          res_next = rnd[31:0];
        end
      end
      default: begin
        res_next = '0;
        sat_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
      sat <= sat_next;
    end
  end

endmodule

/* sv/vau_norm.sv */
// Common left shift of both magnitudes ahead of normalisation.
module vau_norm
  import vau_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [2:0]  kind,
  input  logic [31:0] u_x,
  input  logic [31:0] u_y,
  output logic [31:0] n_x,
  output logic [31:0] n_y,
  output logic        zero
);

  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] m;
  logic        is_zero;

  // Shifts of 16, 8, 4, 2 and 1 bring the larger magnitude into [2^30, 2^31].
  always_comb begin
    x       = u_x;
    y       = u_y;
    m       = (u_x > u_y) ? u_x : u_y;
    is_zero = (m == '0);
    if (kind == KIND_NORM) begin
      for (int j = 0; j < 5; j++) begin
        if (m < (32'd1 << (31 - (16 >> j)))) begin
          x = x << (16 >> j);
          y = y << (16 >> j);
          m = m << (16 >> j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_x  <= x;
      n_y  <= y;
      zero <= is_zero;
    end
  end

endmodule

/* sv/vau_sqrt.sv */
// Pipelined rounded square root of the sum of squares, one root bit a stage.
module vau_sqrt
  import vau_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  side_t       side_in,
  output side_t       side_out,
  output logic [31:0] len
);

  logic [63:0] sq_x;
  logic [63:0] sq_y;
  side_t       side_p [0:SQRT_LAT-1];
  logic [63:0] rad    [0:SQRT_STEPS];
  logic [32:0] rem    [0:SQRT_STEPS];
  logic [31:0] root   [0:SQRT_STEPS];
  logic [32:0] rem_nxt  [1:SQRT_STEPS];
  logic [31:0] root_nxt [1:SQRT_STEPS];

  always_comb begin
    logic [34:0] rem2;
    logic [34:0] trial;
    logic        ge;
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      rem2  = {rem[k-1], rad[k-1][2*(SQRT_STEPS-k) +: 2]};
      trial = {1'b0, root[k-1], 2'b01};
      ge    = (rem2 >= trial);
      rem_nxt[k]  = ge ? 33'(rem2 - trial) : 33'(rem2);
      root_nxt[k] = {root[k-1][30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x      <= 64'(side_in.u_x) * 64'(side_in.u_x);
      sq_y      <= 64'(side_in.u_y) * 64'(side_in.u_y);
      side_p[0] <= side_in;
      for (int s = 1; s < SQRT_LAT; s++) begin
        side_p[s] <= side_p[s-1];
      end
      rad[0]  <= sq_x + sq_y;
      rem[0]  <= '0;
      root[0] <= '0;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
        rad[k]  <= rad[k-1];
        rem[k]  <= rem_nxt[k];
        root[k] <= root_nxt[k];
      end
      // The remainder is the radicand less the floor root squared.
      len <= root[SQRT_STEPS] + 32'((rem[SQRT_STEPS] > {1'b0, root[SQRT_STEPS]}) ? 1 : 0);
    end
  end

  assign side_out = side_p[SQRT_LAT-1];

endmodule

/* sv/vau_div.sv */
// One lane of the pipelined rounded divider that forms a unit-vector component.
module vau_div
  import vau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        u,
  input  logic [31:0]        len,
  output logic [FRAC_BITS:0] q
);

  localparam int DW    = 32 + FRAC_BITS;
  localparam int STEPS = FRAC_BITS + 1;

  logic [DW-1:0]      dvd_c;
  logic [DW-1:0]      dd  [0:STEPS];
  logic [31:0]        ln  [0:STEPS];
  logic [31:0]        rem [0:STEPS];
  logic [FRAC_BITS:0] qp  [0:STEPS];
  logic [31:0]        rem_nxt [1:STEPS];
  logic [FRAC_BITS:0] q_nxt   [1:STEPS];

  assign dvd_c = {u, FRAC_BITS'(0)} + DW'(len >> 1);

  // The quotient stays below 2^(FRAC_BITS+1), so the top bits start below the divisor.
  always_comb begin
    logic [32:0] rem2;
    logic        ge;
    for (int k = 1; k <= STEPS; k++) begin
      rem2 = {rem[k-1], dd[k-1][STEPS-k]};
      ge   = (rem2 >= {1'b0, ln[k-1]});
      rem_nxt[k] = ge ? 32'(rem2 - {1'b0, ln[k-1]}) : rem2[31:0];
      q_nxt[k]   = {qp[k-1][FRAC_BITS-1:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0]  <= dvd_c;
      ln[0]  <= len;
      rem[0] <= {1'b0, dvd_c[DW-1:STEPS]};
      qp[0]  <= '0;
      for (int k = 1; k <= STEPS; k++) begin
        dd[k]  <= dd[k-1];
        ln[k]  <= ln[k-1];
        rem[k] <= rem_nxt[k];
        qp[k]  <= q_nxt[k];
      end
    end
  end

  assign q = qp[STEPS];

endmodule

/* sv/vector2d_arithmetic_unit_top.sv */
// Top level of the two-dimensional vector arithmetic unit.
//
// Items arrive on the req channel (kind, a_x, a_y, b_x, b_y, factor) and one
// result item per request leaves on the rsp channel (r_x, r_y, magnitude,
// saturated), in order. Values are signed fixed point with FRAC_BITS fraction
// bits (8 to 24). Kinds: add, subtract, scale, length and normalise; unused
// codes give an all-zero result.
// One item is taken every cycle while req.ready is high. The path from
// acceptance to the result showing on rsp runs through the input register
// and x/y lanes, the square-root pipeline, which gives one root bit per
// stage, and the per-lane divider pipeline.
// Every item takes that path, whatever its kind.
// When rsp stalls, the result stays in the output register and one more item
// is caught in a skid register; the whole pipeline then holds and req.ready
// drops until the skid register empties.
// Reset (rst, synchronous) drops every valid bit: pipeline, output and skid.
module vector2d_arithmetic_unit_top
  import vau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  vau_req_if.sink   req,
  vau_rsp_if.source rsp
);

  localparam int DIV_LAT = FRAC_BITS + 2;
  localparam int TOTAL   = 3 + SQRT_LAT + DIV_LAT;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic [30:0]        magnitude;
    logic               saturated;
  } res_t;

  logic               adv;
  logic [TOTAL-1:0]   vld;
  logic [2:0]         kind1;
  logic [2:0]         kind2;
  logic [2:0]         kind3;
  logic signed [31:0] ax1;
  logic signed [31:0] ay1;
  logic signed [31:0] bx1;
  logic signed [31:0] by1;
  logic signed [31:0] f1;
  logic [1:0]         neg2;
  logic [1:0]         neg3;
  logic [31:0]        abs_x;
  logic [31:0]        abs_y;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic               sat_x;
  logic               sat_y;
  logic [31:0]        n_x;
  logic [31:0]        n_y;
  logic               zero;
  side_t              side_in;
  side_t              side_s;
  logic [31:0]        len_s;
  logic [FRAC_BITS:0] q_x;
  logic [FRAC_BITS:0] q_y;
  tail_t              tail [0:DIV_LAT-1];
  tail_t              last;
  logic [31:0]        qe_x;
  logic [31:0]        qe_y;
  res_t               merged;
  res_t               o_res;
  res_t               s_res;
  logic               o_vld;
  logic               s_vld;
  logic               take;
  logic               push;

  assign adv       = !s_vld;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOTAL-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1 <= req.kind;
      ax1   <= req.a_x;
      ay1   <= req.a_y;
      bx1   <= req.b_x;
      by1   <= req.b_y;
      f1    <= req.factor;
      kind2 <= kind1;
      kind3 <= kind2;
      neg2  <= {ay1[31], ax1[31]};
      neg3  <= neg2;
    end
  end

  vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk   (clk),
    .en    (adv),
    .kind  (kind1),
    .a     (ax1),
    .b     (bx1),
    .f     (f1),
    .abs_a (abs_x),
    .res   (res_x),
    .sat   (sat_x)
  );

  vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk   (clk),
    .en    (adv),
    .kind  (kind1),
    .a     (ay1),
    .b     (by1),
    .f     (f1),
    .abs_a (abs_y),
    .res   (res_y),
    .sat   (sat_y)
  );

  vau_norm u_norm (
    .clk  (clk),
    .en   (adv),
    .kind (kind2),
    .u_x  (abs_x),
    .u_y  (abs_y),
    .n_x  (n_x),
    .n_y  (n_y),
    .zero (zero)
  );

  always_comb begin
    side_in.kind  = kind3;
    side_in.neg   = neg3;
    side_in.zero  = zero;
    side_in.sat   = sat_x | sat_y;
    side_in.res_x = res_x;
    side_in.res_y = res_y;
    side_in.u_x   = n_x;
    side_in.u_y   = n_y;
  end

  vau_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .side_in  (side_in),
    .side_out (side_s),
    .len      (len_s)
  );

  vau_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk (clk),
    .en  (adv),
    .u   (side_s.u_x),
    .len (len_s),
    .q   (q_x)
  );

  vau_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk (clk),
    .en  (adv),
    .u   (side_s.u_y),
    .len (len_s),
    .q   (q_y)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      tail[0] <= '{side: side_s, len: len_s};
      for (int s = 1; s < DIV_LAT; s++) begin
        tail[s] <= tail[s-1];
      end
    end
  end

  assign last = tail[DIV_LAT-1];
  assign qe_x = 32'(q_x);
  assign qe_y = 32'(q_y);

  // Merge the lane results according to the kind of the item.
  always_comb begin
    merged = '0;
    case (last.side.kind) inside
      KIND_ADD, KIND_SUB, KIND_SCALE: begin
        merged.r_x       = last.side.res_x;
        merged.r_y       = last.side.res_y;
        merged.saturated = last.side.sat;
      end
      KIND_LENGTH: begin
        merged.magnitude = last.len[31] ? MAX_MAG : last.len[30:0];
        merged.saturated = last.len[31];
      end
      KIND_NORM: begin
        if (!last.side.zero) begin
          merged.r_x = last.side.neg[0] ? -qe_x : qe_x;
          merged.r_y = last.side.neg[1] ? -qe_y : qe_y;
        end
      end
      default: begin
        merged = '0;
      end
    endcase
  end

  assign take = o_vld && rsp.ready;
  assign push = adv && vld[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
      s_vld <= 1'b0;
    end else if (s_vld) begin
      if (take) begin
        o_res <= s_res;
        s_vld <= 1'b0;
      end
    end else if (push) begin
      if (!o_vld || take) begin
        o_res <= merged;
        o_vld <= 1'b1;
      end else begin
        s_res <= merged;
        s_vld <= 1'b1;
      end
    end else if (take) begin
      o_vld <= 1'b0;
    end
  end

  assign rsp.valid     = o_vld;
  assign rsp.r_x       = o_res.r_x;
  assign rsp.r_y       = o_res.r_y;
  assign rsp.magnitude = o_res.magnitude;
  assign rsp.saturated = o_res.saturated;

endmodule
